>>> rtl/core/display_vram_pixel_fetch_assert.svh
// Assertion macros shared by the video memory fetch block.
// Included by dvpf_engine, which checks its own control logic; needs no package.
`ifndef DISPLAY_VRAM_PIXEL_FETCH_ASSERT_SVH
`define DISPLAY_VRAM_PIXEL_FETCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DVPF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DVPF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/dvpf_pkg.sv
// Shared types, constants and helper functions for the video memory fetch block.
// No dependencies; used by dvpf_engine and display_vram_pixel_fetch.
package dvpf_pkg;

   // Memory geometry and display constants.
   localparam int VRAM_WORDS    = 65536;
   localparam int VRAM_AW       = $clog2(VRAM_WORDS);
   localparam int VRAM_DW       = 17;
   localparam int DISPLAY_LINES = 480;

   // Line pointer tables are given as byte addresses in octal; we keep word addresses.
   localparam logic [15:0] TABLE0_BASE = 16'(16'o15574 >> 1);
   localparam logic [15:0] TABLE1_BASE = 16'(16'o05574 >> 1);

   // Operation codes carried by an input item.
   typedef enum logic [2:0] {
      MODE_SET_ADDR  = 3'd0,
      MODE_RD_ADDR   = 3'd1,
      MODE_WR_VIA    = 3'd2,
      MODE_RD_VIA    = 3'd3,
      MODE_WR_DIRECT = 3'd4,
      MODE_RD_DIRECT = 3'd5,
      MODE_CTRL_WR   = 3'd6,
      MODE_FETCH     = 3'd7
   } mode_type;

   // Configuration registers as seen by the engine.
   typedef struct packed {
      logic page_select;
      logic interlace_mode;
   } cfg_type;

   // One access to the single-port video memory.
   typedef struct packed {
      logic                   en;
      logic                   we;
      logic [VRAM_AW-1:0]     addr;
      logic [VRAM_DW-1:0]     wdata;
   } mem_req_type;

   // Reduce a 16-bit word address into the memory; the depth is at least 16K words,
   // so at most three subtractions are needed.
   function automatic logic [VRAM_AW-1:0] wrap_addr(logic [15:0] a);
      logic [16:0] v;
      v = {1'b0, a};
      for (int i = 0; i < 3; i++) begin
         if (v >= 17'(VRAM_WORDS)) begin
            v = v - 17'(VRAM_WORDS);
         end
      end
      return v[VRAM_AW-1:0];
   endfunction

   // Expand one memory word into eight 4-bit pixels, leftmost in bits 3:0.
   function automatic logic [31:0] expand_word(logic [16:0] w);
      logic [31:0] px;
      logic [3:0]  nib;
      px = '0;
      if (w[16]) begin
         // High resolution: each nibble gives two equal pixels.
         for (int k = 0; k < 4; k++) begin
            nib = w[15-4*k -: 4];
            px[8*k +: 4]   = nib;
            px[8*k+4 +: 4] = nib;
         end
      end else begin
         // Low resolution: each 2-bit pair gives one pixel scaled by five.
         for (int k = 0; k < 8; k++) begin
            nib = 4'(w[15-2*k -: 2]) * 4'd5;
            px[4*k +: 4] = nib;
         end
      end
      return px;
   endfunction

endpackage

>>> rtl/core/display_vram_pixel_fetch.sv
// Video memory with host access and pixel fetch: configuration port and top level.
// Depends on dvpf_pkg, dvpf_ram and dvpf_engine.

// The block holds a 17-bit video memory in one single-port RAM with a registered
// read. After reset it runs a clearing pass over all VRAM_WORDS (65536) words, during
// which req_ready stays low; configuration writes are taken at all times. Address set,
// control writes and fetches of a line beyond the display finish in the idle state.
// Address reads pass through the result state; memory reads and byte-masked writes
// first read the word, then give the result or do the write-back; a pixel fetch reads
// the line pointer and then the data word, since both reads share the one RAM port in
// sequence. A finished result waits in an output register; the block only stalls on it
// when the next result is ready before the previous one was taken.
module display_vram_pixel_fetch (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_addr,
   input  logic [15:0] req_wdata,
   input  logic [1:0]  req_byte_enable,
   input  logic [8:0]  req_line,
   input  logic [6:0]  req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_rdata,
   output logic        rsp_hires_request,
   output logic [31:0] rsp_pixels,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                         page_ff, page_in;
   logic                         ilace_ff, ilace_in;
   logic                         csr_wr;
   dvpf_pkg::cfg_type            cfg;
   dvpf_pkg::mem_req_type        mem_req;
   logic [dvpf_pkg::VRAM_DW-1:0] mem_rdata;

   // Configuration registers: page_select at 0, interlace_mode at 4.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      page_in  = page_ff;
      ilace_in = ilace_ff;
      if (csr_wr) begin
         if (paddr[2]) begin
            ilace_in = pwdata[0];
         end else begin
            page_in = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff  <= 1'b0;
         ilace_ff <= 1'b0;
      end else begin
         page_ff  <= page_in;
         ilace_ff <= ilace_in;
      end
   end

   assign prdata             = {31'b0, paddr[2] ? ilace_ff : page_ff};
   assign cfg.page_select    = page_ff;
   assign cfg.interlace_mode = ilace_ff;

   // Video memory.
   dvpf_ram #(
      .DEPTH (dvpf_pkg::VRAM_WORDS),
      .DW    (dvpf_pkg::VRAM_DW)
   ) u_ram (
      .clock (clock),
      .en    (mem_req.en),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   // Access and fetch sequencer.
   dvpf_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_addr          (req_addr),
      .req_wdata         (req_wdata),
      .req_byte_enable   (req_byte_enable),
      .req_line          (req_line),
      .req_word_index    (req_word_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rdata         (rsp_rdata),
      .rsp_hires_request (rsp_hires_request),
      .rsp_pixels        (rsp_pixels),
      .mem_req           (mem_req),
      .mem_rdata         (mem_rdata)
   );

endmodule

>>> rtl/core/dvpf_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; instantiated by display_vram_pixel_fetch for the video memory.
module dvpf_ram #(
   parameter int DEPTH = 65536,
   parameter int DW    = 17,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   // Write, or read into the output register, one access per cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/dvpf_engine.sv
// Sequencer for host accesses and pixel fetches over the video memory.
// Depends on dvpf_pkg and display_vram_pixel_fetch_assert.svh; drives the memory port.
`include "display_vram_pixel_fetch_assert.svh"

module dvpf_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  dvpf_pkg::cfg_type            cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic [15:0]                  req_addr,
   input  logic [15:0]                  req_wdata,
   input  logic [1:0]                   req_byte_enable,
   input  logic [8:0]                   req_line,
   input  logic [6:0]                   req_word_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [15:0]                  rsp_rdata,
   output logic                         rsp_hires_request,
   output logic [31:0]                  rsp_pixels,
   output dvpf_pkg::mem_req_type        mem_req,
   input  logic [dvpf_pkg::VRAM_DW-1:0] mem_rdata
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MERGE = 5'b00100,
      ST_PTR   = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   localparam logic [dvpf_pkg::VRAM_AW-1:0] VRAM_LAST =
      dvpf_pkg::VRAM_AW'(dvpf_pkg::VRAM_WORDS - 1);

   state_type                     state_ff, state_in;
   logic [dvpf_pkg::VRAM_AW-1:0]  clr_ff, clr_in;
   logic [15:0]                   addr_ff, addr_in;
   logic [7:0]                    ctrl_ff, ctrl_in;
   dvpf_pkg::mode_type            op_ff, op_in;
   logic [dvpf_pkg::VRAM_AW-1:0]  tgt_ff, tgt_in;
   logic [15:0]                   wdata_ff, wdata_in;
   logic [1:0]                    be_ff, be_in;
   logic [6:0]                    widx_ff, widx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_rdata_ff, rsp_rdata_in;
   logic                          rsp_hires_ff, rsp_hires_in;
   logic [31:0]                   rsp_pixels_ff, rsp_pixels_in;

   dvpf_pkg::mode_type            mode;
   logic [8:0]                    eff_line;
   logic [15:0]                   ptr_addr;
   logic                          line_ok;
   logic [15:0]                   wmask;
   logic [15:0]                   merged;
   logic                          accept;
   logic                          out_free;

   // Decode of the incoming item.
   assign mode      = dvpf_pkg::mode_type'(req_mode);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign line_ok   = 32'(req_line) < dvpf_pkg::DISPLAY_LINES;
   assign eff_line  = cfg.interlace_mode ? req_line : {req_line[8:1], 1'b0};
   assign ptr_addr  = 16'((cfg.page_select ? dvpf_pkg::TABLE1_BASE : dvpf_pkg::TABLE0_BASE)
                        + 16'(dvpf_pkg::DISPLAY_LINES - 1) - {7'b0, eff_line});

   // Byte merge for the write-back of a read-modify-write.
   assign wmask  = {{8{be_ff[1]}}, {8{be_ff[0]}}};
   assign merged = (mem_rdata[15:0] & ~wmask) | (wdata_ff & wmask);

   // Memory port: clearing pass, first reads, write-back and the dependent data read.
   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = clr_ff;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (mode inside {dvpf_pkg::MODE_WR_VIA, dvpf_pkg::MODE_RD_VIA}) begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = dvpf_pkg::wrap_addr(addr_ff);
               end else if (mode inside {dvpf_pkg::MODE_WR_DIRECT,
                                         dvpf_pkg::MODE_RD_DIRECT}) begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = dvpf_pkg::wrap_addr({2'b0, req_addr[13:0]});
               end else if (mode == dvpf_pkg::MODE_FETCH && line_ok) begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = dvpf_pkg::wrap_addr(ptr_addr);
               end
            end
         end
         ST_MERGE: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = tgt_ff;
            mem_req.wdata = {ctrl_ff[7], merged};
         end
         ST_PTR: begin
            mem_req.en   = 1'b1;
            mem_req.addr = dvpf_pkg::wrap_addr(16'(mem_rdata[15:0] + {9'b0, widx_ff}));
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   // Sequencer and register next values.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      ctrl_in       = ctrl_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      wdata_in      = wdata_ff;
      be_in         = be_ff;
      widx_in       = widx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_hires_in  = rsp_hires_ff;
      rsp_pixels_in = rsp_pixels_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == VRAM_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = mode;
               wdata_in = req_wdata;
               be_in    = req_byte_enable;
               widx_in  = req_word_index;
               case (mode)
                  dvpf_pkg::MODE_SET_ADDR: begin
                     addr_in = req_addr;
                  end
                  dvpf_pkg::MODE_RD_ADDR: begin
                     state_in = ST_RESP;
                  end
                  dvpf_pkg::MODE_WR_VIA: begin
                     tgt_in   = dvpf_pkg::wrap_addr(addr_ff);
                     state_in = ST_MERGE;
                  end
                  dvpf_pkg::MODE_WR_DIRECT: begin
                     tgt_in   = dvpf_pkg::wrap_addr({2'b0, req_addr[13:0]});
                     state_in = ST_MERGE;
                  end
                  dvpf_pkg::MODE_RD_VIA, dvpf_pkg::MODE_RD_DIRECT: begin
                     state_in = ST_RESP;
                  end
                  dvpf_pkg::MODE_CTRL_WR: begin
                     if (req_byte_enable[0]) begin
                        ctrl_in = req_wdata[7:0];
                     end
                  end
                  dvpf_pkg::MODE_FETCH: begin
                     if (line_ok) begin
                        state_in = ST_PTR;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MERGE: begin
            state_in = ST_IDLE;
         end
         ST_PTR: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Load the output register once it is free; read data stays in the RAM register.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rdata_in  = '0;
               rsp_hires_in  = 1'b0;
               rsp_pixels_in = '0;
               case (op_ff)
                  dvpf_pkg::MODE_RD_ADDR: begin
                     rsp_rdata_in = addr_ff;
                  end
                  dvpf_pkg::MODE_RD_VIA: begin
                     rsp_rdata_in = mem_rdata[15:0];
                     rsp_hires_in = mem_rdata[16] ^ ctrl_ff[6];
                  end
                  dvpf_pkg::MODE_RD_DIRECT: begin
                     rsp_rdata_in = mem_rdata[15:0];
                  end
                  dvpf_pkg::MODE_FETCH: begin
                     rsp_pixels_in = dvpf_pkg::expand_word(mem_rdata);
                  end
                  default: begin
                     rsp_rdata_in = '0;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         addr_ff      <= '0;
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         addr_ff      <= addr_in;
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tgt_ff        <= tgt_in;
      wdata_ff      <= wdata_in;
      be_ff         <= be_in;
      widx_ff       <= widx_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_hires_ff  <= rsp_hires_in;
      rsp_pixels_ff <= rsp_pixels_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rdata         = rsp_rdata_ff;
   assign rsp_hires_request = rsp_hires_ff;
   assign rsp_pixels        = rsp_pixels_ff;

   // Checks on the sequencer.
   `DVPF_ASSERT_IMP(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req_ready,
      "item accepted during the clearing pass")
   `DVPF_ASSERT_IMP(a_write_states, clock, reset, mem_req.we,
      state_ff == ST_CLEAR || state_ff == ST_MERGE, "memory written outside clear or merge")
   `DVPF_ASSERT_NEXT(a_ptr_to_resp, clock, reset, state_ff == ST_PTR, state_ff == ST_RESP,
      "pointer read not followed by the data read result")
   `DVPF_ASSERT_NEXT(a_merge_to_idle, clock, reset, state_ff == ST_MERGE, state_ff == ST_IDLE,
      "write-back did not return to idle")
   `DVPF_ASSERT_NEXT(a_resp_loads, clock, reset, state_ff == ST_RESP && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "result not loaded into the output register")

endmodule
